// File: hw/rtl/rti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared widths, types and codes for the ray/triangle tester
// Fixed-point widths of the datapath and the register index codes.
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int CW        = 32;          // coordinate width, Q16.16
   localparam int FRAC      = 16;          // fraction bits
   localparam int EPS_W     = CW - 1;      // det_epsilon width
   localparam int EW        = CW + 1;      // edge / difference width
   localparam int PW        = 2 * EW + 1;  // cross product component width
   localparam int LO_W      = EW;          // low slice of a cross component
   localparam int HI_W      = PW - LO_W;   // high slice (signed)
   localparam int PART_W    = EW + HI_W;   // partial product width
   localparam int DW        = EW + PW + 2; // dot product width
   localparam int QW        = CW;          // quotient bits kept
   localparam int RW        = DW + QW;     // divider remainder width
   localparam int CSR_IDX_W = 3;

   typedef logic signed [CW-1:0]     coord_type;
   typedef logic signed [EW-1:0]     edge_type;
   typedef logic signed [2*EW-1:0]   xprod_type;
   typedef logic signed [PW-1:0]     cross_type;
   typedef logic signed [PART_W-1:0] part_type;
   typedef logic signed [DW-1:0]     dot_type;
   typedef logic        [DW-1:0]     mag_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5,
      CSR_EPSILON  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic hit;   // triangle hit
      logic tneg;  // distance negative
      logic ovf;   // quotient beyond 32 bits
   } div_meta_type;

endpackage
`default_nettype wire

// File: hw/rtl/rti_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div: pipelined distance divider
// One restoring quotient bit per stage, then saturation and sign.
// ----------------------------------------------------------------------------
module rti_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rti_pkg::mag_type      in_dmag,
   input  wire rti_pkg::mag_type      in_mag,
   input  wire rti_pkg::div_meta_type in_meta,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic                       out_hit,
   output rti_pkg::coord_type         out_dist
);

   localparam int NS = rti_pkg::QW + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic [rti_pkg::RW-1:0]   rem_ff  [rti_pkg::QW];
   logic [rti_pkg::QW-1:0]   quo_ff  [rti_pkg::QW];
   rti_pkg::mag_type         dmag_ff [rti_pkg::QW];
   rti_pkg::div_meta_type    meta_ff [rti_pkg::QW];

   logic [rti_pkg::RW-1:0]   rem_src [rti_pkg::QW];
   logic [rti_pkg::QW-1:0]   quo_src [rti_pkg::QW];
   rti_pkg::mag_type         dmag_src[rti_pkg::QW];
   rti_pkg::div_meta_type    meta_src[rti_pkg::QW];
   logic [rti_pkg::RW-1:0]   rem_in  [rti_pkg::QW];
   logic [rti_pkg::QW-1:0]   quo_in  [rti_pkg::QW];

   logic [rti_pkg::RW-1:0]   shifted;
   logic                     take;
   logic [rti_pkg::QW-1:0]   lim;
   logic [rti_pkg::QW-1:0]   qsat;
   logic [rti_pkg::QW-1:0]   signed_quo;
   logic                     hit_ff;
   rti_pkg::coord_type       dist_ff;

   // stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? in_valid : v_ff[i-1];
            end
         end
      end
   end

   // one quotient bit per stage, divisor shift fixed per stage
   always_comb begin
      shifted = '0;
      take    = 1'b0;
      for (int g = 0; g < rti_pkg::QW; g++) begin
         if (g == 0) begin
            rem_src[g]  = rti_pkg::RW'(in_mag) << rti_pkg::FRAC;
            quo_src[g]  = '0;
            dmag_src[g] = in_dmag;
            meta_src[g] = in_meta;
         end else begin
            rem_src[g]  = rem_ff[g-1];
            quo_src[g]  = quo_ff[g-1];
            dmag_src[g] = dmag_ff[g-1];
            meta_src[g] = meta_ff[g-1];
         end
         shifted   = rti_pkg::RW'(dmag_src[g]) << (rti_pkg::QW - 1 - g);
         take      = rem_src[g] >= shifted;
         rem_in[g] = take ? rem_src[g] - shifted : rem_src[g];
         quo_in[g] = {quo_src[g][rti_pkg::QW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < rti_pkg::QW; g++) begin
         if (en[g]) begin
            rem_ff[g]  <= rem_in[g];
            quo_ff[g]  <= quo_in[g];
            dmag_ff[g] <= dmag_src[g];
            meta_ff[g] <= meta_src[g];
         end
      end
   end

   // saturate to the signed range, apply sign, zero on a miss
   always_comb begin
      lim = rti_pkg::QW'(1) << (rti_pkg::QW - 1);
      if (!meta_ff[rti_pkg::QW-1].tneg) begin
         lim = lim - rti_pkg::QW'(1);
      end
      qsat = (meta_ff[rti_pkg::QW-1].ovf || quo_ff[rti_pkg::QW-1] > lim)
             ? lim : quo_ff[rti_pkg::QW-1];
      signed_quo = meta_ff[rti_pkg::QW-1].tneg ? -qsat : qsat;
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         hit_ff  <= meta_ff[rti_pkg::QW-1].hit;
         dist_ff <= meta_ff[rti_pkg::QW-1].hit ? rti_pkg::coord_type'(signed_quo) : '0;
      end
   end

   assign out_hit  = hit_ff;
   assign out_dist = dist_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ray_triangle_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersection: Moller-Trumbore ray/triangle test
// Streams triangles against one ray held in registers, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_*: write port for the ray (origin, direction) and det_epsilon.
//    Write only while no word is in flight. Index 7 is ignored.
//  - req_*: one triangle word (three vertices), valid/ready.
//  - rsp_*: one result word per triangle: hit flag and distance t
//    (saturated Q16.16, zero on a miss), valid/ready.
// Pipeline: 9 geometry stages, 32 divider stages, one output stage.
// Throughput: one word per cycle while rsp_ready is high; every stage
//  is registered and the divider produces one quotient bit per stage.
// Reset: flushes the pipe; origin 0, direction (0,0,1.0), epsilon 1.
// Stall: a low rsp_ready holds the output word; upstream stages keep
//  filling bubbles, so req_ready drops only once the pipe is full.
// ----------------------------------------------------------------------------
module ray_triangle_intersection (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [rti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rti_pkg::CW-1:0]              csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire rti_pkg::coord_type                  req_vertex0_x,
   input  wire rti_pkg::coord_type                  req_vertex0_y,
   input  wire rti_pkg::coord_type                  req_vertex0_z,
   input  wire rti_pkg::coord_type                  req_vertex1_x,
   input  wire rti_pkg::coord_type                  req_vertex1_y,
   input  wire rti_pkg::coord_type                  req_vertex1_z,
   input  wire rti_pkg::coord_type                  req_vertex2_x,
   input  wire rti_pkg::coord_type                  req_vertex2_y,
   input  wire rti_pkg::coord_type                  req_vertex2_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output rti_pkg::coord_type                       rsp_hit_distance
);

   localparam int NS = 9;

   // ---------------- configuration registers ----------------
   rti_pkg::coord_type            origin_ff[3];
   rti_pkg::coord_type            dir_ff[3];
   logic [rti_pkg::EPS_W-1:0]     eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= rti_pkg::coord_type'(1) <<< rti_pkg::FRAC;
         eps_ff       <= rti_pkg::EPS_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            rti_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_wr_data;
            rti_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_wr_data;
            rti_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_wr_data;
            rti_pkg::CSR_DIR_X:    dir_ff[0]    <= csr_wr_data;
            rti_pkg::CSR_DIR_Y:    dir_ff[1]    <= csr_wr_data;
            rti_pkg::CSR_DIR_Z:    dir_ff[2]    <= csr_wr_data;
            rti_pkg::CSR_EPSILON:  eps_ff       <= csr_wr_data[rti_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;
   logic          div_in_ready;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || div_in_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? req_valid : v_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: edges and origin offset ----------------
   rti_pkg::coord_type v0[3], v1[3], v2[3];
   rti_pkg::edge_type  d_e[3];
   rti_pkg::edge_type  e1_in[3], e2_in[3], s_in[3];
   rti_pkg::edge_type  e1_1_ff[3], e2_1_ff[3], s_1_ff[3];

   assign v0[0] = req_vertex0_x;
   assign v0[1] = req_vertex0_y;
   assign v0[2] = req_vertex0_z;
   assign v1[0] = req_vertex1_x;
   assign v1[1] = req_vertex1_y;
   assign v1[2] = req_vertex1_z;
   assign v2[0] = req_vertex2_x;
   assign v2[1] = req_vertex2_y;
   assign v2[2] = req_vertex2_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_e[i]   = rti_pkg::edge_type'(dir_ff[i]);
         e1_in[i] = rti_pkg::edge_type'(v1[i]) - rti_pkg::edge_type'(v0[i]);
         e2_in[i] = rti_pkg::edge_type'(v2[i]) - rti_pkg::edge_type'(v0[i]);
         s_in[i]  = rti_pkg::edge_type'(origin_ff[i]) - rti_pkg::edge_type'(v0[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_1_ff <= e1_in;
         e2_1_ff <= e2_in;
         s_1_ff  <= s_in;
      end
   end

   // ---------------- stage 2: cross product terms ----------------
   // p = dir x e2, q = s x e1; each component is m - n
   rti_pkg::xprod_type pm_in[3], pn_in[3], qm_in[3], qn_in[3];
   rti_pkg::xprod_type pm_ff[3], pn_ff[3], qm_ff[3], qn_ff[3];
   rti_pkg::edge_type  e1_2_ff[3], e2_2_ff[3], s_2_ff[3];

   always_comb begin
      pm_in[0] = d_e[1] * e2_1_ff[2];
      pn_in[0] = d_e[2] * e2_1_ff[1];
      pm_in[1] = d_e[2] * e2_1_ff[0];
      pn_in[1] = d_e[0] * e2_1_ff[2];
      pm_in[2] = d_e[0] * e2_1_ff[1];
      pn_in[2] = d_e[1] * e2_1_ff[0];
      qm_in[0] = s_1_ff[1] * e1_1_ff[2];
      qn_in[0] = s_1_ff[2] * e1_1_ff[1];
      qm_in[1] = s_1_ff[2] * e1_1_ff[0];
      qn_in[1] = s_1_ff[0] * e1_1_ff[2];
      qm_in[2] = s_1_ff[0] * e1_1_ff[1];
      qn_in[2] = s_1_ff[1] * e1_1_ff[0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pm_ff   <= pm_in;
         pn_ff   <= pn_in;
         qm_ff   <= qm_in;
         qn_ff   <= qn_in;
         e1_2_ff <= e1_1_ff;
         e2_2_ff <= e2_1_ff;
         s_2_ff  <= s_1_ff;
      end
   end

   // ---------------- stage 3: cross product differences ----------------
   rti_pkg::cross_type p_in[3], q_in[3], p_ff[3], q_ff[3];
   rti_pkg::edge_type  e1_3_ff[3], e2_3_ff[3], s_3_ff[3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i] = rti_pkg::cross_type'(pm_ff[i]) - rti_pkg::cross_type'(pn_ff[i]);
         q_in[i] = rti_pkg::cross_type'(qm_ff[i]) - rti_pkg::cross_type'(qn_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         e1_3_ff <= e1_2_ff;
         e2_3_ff <= e2_2_ff;
         s_3_ff  <= s_2_ff;
      end
   end

   // ---------------- stage 4: dot partial products ----------------
   // dots: 0 det = e1.p, 1 u = s.p, 2 v = dir.q, 3 t = e2.q
   // wide factor split into unsigned low and signed high slices
   rti_pkg::edge_type  da[4][3];
   rti_pkg::cross_type db[4][3];
   rti_pkg::part_type  pl_in[4][3], ph_in[4][3], pl_ff[4][3], ph_ff[4][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         da[0][i] = e1_3_ff[i];
         db[0][i] = p_ff[i];
         da[1][i] = s_3_ff[i];
         db[1][i] = p_ff[i];
         da[2][i] = d_e[i];
         db[2][i] = q_ff[i];
         da[3][i] = e2_3_ff[i];
         db[3][i] = q_ff[i];
      end
      for (int n = 0; n < 4; n++) begin
         for (int i = 0; i < 3; i++) begin
            pl_in[n][i] = da[n][i] * $signed({1'b0, db[n][i][rti_pkg::LO_W-1:0]});
            ph_in[n][i] = da[n][i] * $signed(db[n][i][rti_pkg::PW-1:rti_pkg::LO_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
      end
   end

   // ---------------- stage 5: join partials ----------------
   rti_pkg::dot_type prod_in[4][3], prod_ff[4][3];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[n][i] = (rti_pkg::dot_type'(ph_ff[n][i]) <<< rti_pkg::LO_W)
                          + rti_pkg::dot_type'(pl_ff[n][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------- stage 6: dot sums ----------------
   rti_pkg::dot_type acc_in[4], acc_ff[4];

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         acc_in[n] = prod_ff[n][0] + prod_ff[n][1] + prod_ff[n][2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------- stage 7: fold sign of det ----------------
   logic             dneg;
   rti_pkg::mag_type dmag_in, mag_in, dmag_7_ff, mag_7_ff;
   rti_pkg::dot_type un_in, vn_in, un_ff, vn_ff;
   logic             tneg_in, tneg_7_ff;

   always_comb begin
      dneg    = acc_ff[0][rti_pkg::DW-1];
      dmag_in = dneg ? $unsigned(-acc_ff[0]) : $unsigned(acc_ff[0]);
      un_in   = dneg ? -acc_ff[1] : acc_ff[1];
      vn_in   = dneg ? -acc_ff[2] : acc_ff[2];
      tneg_in = (acc_ff[3] != '0) && (acc_ff[3][rti_pkg::DW-1] ^ dneg);
      mag_in  = acc_ff[3][rti_pkg::DW-1] ? $unsigned(-acc_ff[3]) : $unsigned(acc_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         dmag_7_ff <= dmag_in;
         mag_7_ff  <= mag_in;
         un_ff     <= un_in;
         vn_ff     <= vn_in;
         tneg_7_ff <= tneg_in;
      end
   end

   // ---------------- stage 8: range flags ----------------
   logic signed [rti_pkg::DW:0] sum_in, sum_ff;
   logic             nz_in, thr_in, u_in, v_in, ovf_in;
   logic             nz_ff, thr_ff, u_ff, v_ff8, ovf_8_ff, tneg_8_ff;
   rti_pkg::mag_type dmag_8_ff, mag_8_ff;

   always_comb begin
      sum_in = (rti_pkg::DW+1)'(un_ff) + (rti_pkg::DW+1)'(vn_ff);
      nz_in  = dmag_7_ff != '0;
      thr_in = dmag_7_ff >= (rti_pkg::DW'(eps_ff) << (2 * rti_pkg::FRAC));
      u_in   = !un_ff[rti_pkg::DW-1] && ($unsigned(un_ff) <= dmag_7_ff);
      v_in   = !vn_ff[rti_pkg::DW-1];
      // quotient needs more than QW bits
      ovf_in = (rti_pkg::DW+rti_pkg::FRAC)'(mag_7_ff)
               >= ((rti_pkg::DW+rti_pkg::FRAC)'(dmag_7_ff) << rti_pkg::FRAC);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         sum_ff    <= sum_in;
         nz_ff     <= nz_in;
         thr_ff    <= thr_in;
         u_ff      <= u_in;
         v_ff8     <= v_in;
         ovf_8_ff  <= ovf_in;
         tneg_8_ff <= tneg_7_ff;
         dmag_8_ff <= dmag_7_ff;
         mag_8_ff  <= mag_7_ff;
      end
   end

   // ---------------- stage 9: hit decision ----------------
   logic                  hit_in;
   rti_pkg::div_meta_type meta_ff;
   rti_pkg::mag_type      dmag_9_ff, mag_9_ff;

   always_comb begin
      hit_in = nz_ff && thr_ff && u_ff && v_ff8 && !sum_ff[rti_pkg::DW]
               && ($unsigned(sum_ff) <= (rti_pkg::DW+1)'(dmag_8_ff));
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         meta_ff.hit  <= hit_in;
         meta_ff.tneg <= tneg_8_ff;
         meta_ff.ovf  <= ovf_8_ff;
         dmag_9_ff    <= dmag_8_ff;
         mag_9_ff     <= mag_8_ff;
      end
   end

   // ---------------- distance divider and output register ----------------
   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[NS-1]),
      .in_ready  (div_in_ready),
      .in_dmag   (dmag_9_ff),
      .in_mag    (mag_9_ff),
      .in_meta   (meta_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hit   (rsp_hit),
      .out_dist  (rsp_hit_distance)
   );

endmodule
`default_nettype wire

// File: tb/ray_triangle_intersection_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersection_test: self-checking bench for the ray tester
// Streams triangles against a handful of ray settings, predicts each hit
// flag and distance with exact wide integer math, and compares every
// result word in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_test;
   import rti_pkg::*;

   localparam int                 CYCLE_LIMIT = 600000;
   localparam int                 PHASE_ITEMS = 215;
   localparam int                 DRAIN_WAIT  = 60;    // pipe is 42 deep
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7; // decoded as no-op

   typedef logic signed [255:0] wide_type;            // roomy exact math

   typedef struct {
      coord_type v [9];   // v0 xyz, v1 xyz, v2 xyz
   } triangle_type;

   typedef struct {
      logic      hit;
      coord_type hit_dist;
   } hit_word_type;

   // -------------------------------------------------------------------------
   // Intersection predictor and queue of pending result words
   // -------------------------------------------------------------------------
   class hit_scoreboard;
      coord_type    origin [3];
      coord_type    dir [3];
      logic [EPS_W-1:0] eps;
      hit_word_type pending [$];
      int           errors;

      function new();
         origin = '{0, 0, 0};
         dir    = '{0, 0, 32'sd65536};
         eps    = 1;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CW-1:0] val);
         case (idx)
            CSR_ORIGIN_X: origin[0] = val;
            CSR_ORIGIN_Y: origin[1] = val;
            CSR_ORIGIN_Z: origin[2] = val;
            CSR_DIR_X:    dir[0]    = val;
            CSR_DIR_Y:    dir[1]    = val;
            CSR_DIR_Z:    dir[2]    = val;
            CSR_EPSILON:  eps       = val[EPS_W-1:0];
            default: ;
         endcase
      endfunction

      function void cross_prod(input wide_type a [3], input wide_type b [3],
                               output wide_type r [3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function wide_type dot(input wide_type a [3], input wide_type b [3]);
         return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      endfunction

      // Moller-Trumbore with exact rational compares; det sign folded in
      function hit_word_type predict(triangle_type t);
         wide_type     d [3], e1 [3], e2 [3], s [3], p [3], q [3];
         wide_type     det, un, vn, tn, thr;
         logic [255:0] mag, quo, lim;
         logic         tneg;
         hit_word_type w;
         for (int i = 0; i < 3; i++) begin
            d[i]  = wide_type'(dir[i]);
            e1[i] = wide_type'(t.v[3+i]) - wide_type'(t.v[i]);
            e2[i] = wide_type'(t.v[6+i]) - wide_type'(t.v[i]);
            s[i]  = wide_type'(origin[i]) - wide_type'(t.v[i]);
         end
         cross_prod(d, e2, p);
         det = dot(e1, p);
         un  = dot(s, p);
         cross_prod(s, e1, q);
         vn  = dot(d, q);
         tn  = dot(e2, q);
         if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
         end
         thr   = wide_type'({1'b0, eps}) <<< (2 * FRAC);
         w.hit = det != 0 && det >= thr && un >= 0 && un <= det
                 && vn >= 0 && un + vn >= 0 && un + vn <= det;
         w.hit_dist = '0;
         if (w.hit) begin
            tneg = tn < 0;
            mag  = tneg ? -tn : tn;
            quo  = (mag << FRAC) / det;
            lim  = tneg ? 256'h8000_0000 : 256'h7fff_ffff;
            if (quo > lim) quo = lim;
            if (tneg) quo = -quo;
            w.hit_dist = quo[CW-1:0];
         end
         return w;
      endfunction

      function void note_triangle(triangle_type t);
         pending = {pending, predict(t)};
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_word(logic hit, coord_type hit_dist);
         hit_word_type w;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word hit=%0b t=%0d", hit, hit_dist));
            return;
         end
         w = pending.pop_front();
         if (hit !== w.hit)
            report($sformatf("hit %0b, want %0b", hit, w.hit));
         if (hit_dist !== w.hit_dist)
            report($sformatf("hit_distance %0d, want %0d", hit_dist, w.hit_dist));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT signals, the driven ones known from time zero
   // -------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CW-1:0]        csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   coord_type            req_v [9]   = '{default: '0};
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic                 rsp_hit;
   coord_type            rsp_hit_distance;

   hit_scoreboard sb = new();
   int            cycles = 0;
   logic          calm = 1'b0;   // stretches with no idling on either side
   int            stall_left = 0;

   ray_triangle_intersection u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vertex0_x    (req_v[0]),
      .req_vertex0_y    (req_v[1]),
      .req_vertex0_z    (req_v[2]),
      .req_vertex1_x    (req_v[3]),
      .req_vertex1_y    (req_v[4]),
      .req_vertex1_z    (req_v[5]),
      .req_vertex2_x    (req_v[6]),
      .req_vertex2_y    (req_v[7]),
      .req_vertex2_z    (req_v[8]),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_hit_distance (rsp_hit_distance)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none while calm
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure; calm flips now and then
   always @(posedge clock) begin
      if ($urandom_range(199) == 0) calm <= ~calm;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= gap_len();
      end
   end

   // result monitor; values sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_hit, rsp_hit_distance);
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic coord_type fx(int n);
      return coord_type'(n) <<< FRAC;
   endfunction

   // mix of small values (useful geometry) and full-range noise
   function automatic coord_type rand_coord();
      if ($urandom_range(7) == 0) return $urandom;
      return $urandom_range(0, 32'h0010_0000) - 32'sh0008_0000;
   endfunction

   function automatic triangle_type tri_of(int a0, int a1, int a2, int b0, int b1,
                                           int b2, int c0, int c1, int c2);
      triangle_type t;
      t.v = '{fx(a0), fx(a1), fx(a2), fx(b0), fx(b1), fx(b2), fx(c0), fx(c1), fx(c2)};
      return t;
   endfunction

   // triangle scattered around a point on the ray, so hits are common
   function automatic triangle_type aimed_triangle();
      triangle_type t;
      int           k;
      coord_type    spot;
      k = $urandom_range(0, 8) - 2;
      for (int i = 0; i < 9; i++) begin
         spot   = sb.origin[i % 3] + sb.dir[i % 3] * k;
         t.v[i] = spot + ($urandom_range(0, 32'h0004_0000) - 32'sh0002_0000);
      end
      return t;
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      if ($urandom_range(3) != 0) return aimed_triangle();
      foreach (t.v[i]) t.v[i] = rand_coord();
      return t;
   endfunction

   task automatic send_word(triangle_type t);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_v     <= t.v;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_triangle(t);
   endtask

   // wait until every word is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // leaves csr_wr_en high; the caller drops it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CW-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_ray(coord_type ox, coord_type oy, coord_type oz, coord_type dx,
                          coord_type dy, coord_type dz, logic [CW-1:0] e);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Y, dy);
      csr_write(CSR_DIR_Z, dz);
      csr_write(CSR_EPSILON, e);
      csr_write(CSR_UNUSED, $urandom);   // must not disturb anything
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase();
      repeat (PHASE_ITEMS) send_word(random_triangle());
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      triangle_type t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words against the reset ray: origin 0, direction +z
      send_word(tri_of(-1, -1, 2, 3, -1, 2, -1, 3, 2));    // plain hit, t = 2
      send_word(tri_of(-1, -1, -3, 3, -1, -3, -1, 3, -3)); // hit behind origin
      send_word(tri_of(-1, -1, 2, -1, 3, 2, 3, -1, 2));    // opposite winding
      send_word(tri_of(1, 1, 2, 3, 1, 2, 1, 3, 2));        // outside
      send_word(tri_of(-1, -1, 2, 1, -1, 2, -1, 1, 2));    // on edge, u+v = 1
      send_word(tri_of(0, 0, 5, 2, 0, 5, 0, 2, 5));        // at vertex, u = v = 0
      send_word(tri_of(0, -2, 5, 0, 2, 5, -2, 0, 5));      // on edge, v = 0
      send_word(tri_of(0, 0, 0, 1, 0, 0, 0, 0, 1));        // parallel, det = 0
      t.v = '{0, 0, fx(1), 1, 0, fx(1), 0, 1, fx(1)};      // det below epsilon
      send_word(t);
      t.v = '{default: 32'sh7fff_ffff};
      send_word(t);
      t.v = '{default: 32'sh8000_0000};
      send_word(t);
      t.v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0};
      send_word(t);
      t.v = '{default: '0};
      send_word(t);
      random_phase();

      // skewed ray
      set_ray(32'sh0001_8000, fx(-2), fx(-10), 32'sh0000_4000, 32'sh0000_8000,
              fx(1), 1);
      random_phase();

      // tiny direction: distances saturate both ways, epsilon off
      set_ray(0, 0, 0, 0, 0, 1, 0);
      send_word(tri_of(-1, -1, 1, 3, -1, 1, -1, 3, 1));
      send_word(tri_of(-1, -1, -1, 3, -1, -1, -1, 3, -1));
      random_phase();

      // register extremes, largest epsilon
      set_ray(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'h7fff_ffff);
      random_phase();

      // moderate random ray, small epsilon
      set_ray(rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000,
              $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000,
              fx(1), $urandom_range(0, 4));
      random_phase();

      // full-range random registers
      set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase();

      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: ray_triangle_intersection.f
hw/rtl/rti_pkg.sv
hw/rtl/rti_div.sv
hw/rtl/ray_triangle_intersection.sv
tb/ray_triangle_intersection_test.sv
